// ----- design/hrp_pkg.sv -----
// Shared types, constants and byte-step functions for the HTTP request head parser.
// Used by hrp_parse, hrp_out_stage and http_request_head_parser. No dependencies.
package hrp_pkg;

   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_PATH    = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_HNAME   = 3'd3;
   localparam logic [2:0] PH_HVALUE  = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;
   localparam logic [2:0] PH_ERROR   = 3'd6;

   localparam logic [2:0] ROLE_DELIM   = 3'd0;
   localparam logic [2:0] ROLE_METHOD  = 3'd1;
   localparam logic [2:0] ROLE_PATH    = 3'd2;
   localparam logic [2:0] ROLE_QUERY   = 3'd3;
   localparam logic [2:0] ROLE_VERSION = 3'd4;
   localparam logic [2:0] ROLE_HNAME   = 3'd5;
   localparam logic [2:0] ROLE_HVALUE  = 3'd6;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_REQ_OK   = 3'd1;
   localparam logic [2:0] EV_HDR_DONE = 3'd2;
   localparam logic [2:0] EV_COMPLETE = 3'd3;
   localparam logic [2:0] EV_ERROR    = 3'd4;

   localparam logic [2:0] M_GET    = 3'd0;
   localparam logic [2:0] M_POST   = 3'd1;
   localparam logic [2:0] M_HEAD   = 3'd2;
   localparam logic [2:0] M_PUT    = 3'd3;
   localparam logic [2:0] M_DELETE = 3'd4;
   localparam int NUM_METHODS = 5;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;

   localparam logic [55:0] VER_TEXT    = "HTTP/1.";
   localparam logic [3:0]  VER_PREFIX  = 4'd7;
   localparam logic [3:0]  VER_LEN     = 4'd8;
   localparam logic [3:0]  COUNT_MAX   = 4'd15;

   typedef struct packed {
      logic [2:0] phase;
      logic [3:0] token_count;
      logic [4:0] method_match;
      logic       version_ok;
      logic       minor_digit;
      logic       cr_pending;
      logic       path_in_query;
   } state_type;

   localparam state_type RESET_STATE = '{
      phase:         PH_METHOD,
      token_count:   4'd0,
      method_match:  5'h1F,
      version_ok:    1'b1,
      minor_digit:   1'b0,
      cr_pending:    1'b0,
      path_in_query: 1'b0
   };

   typedef struct packed {
      logic [2:0] role;
      logic [7:0] out_byte;
      logic [2:0] event_res;
      logic [2:0] method_code;
      logic       http_minor;
   } result_type;

   typedef struct packed {
      state_type  st;
      logic [2:0] role;
   } content_type;

   typedef struct packed {
      state_type  st;
      logic [2:0] event_res;
      logic [2:0] method_code;
      logic       http_minor;
   } line_type;

   function automatic logic [3:0] meth_len(logic [2:0] m);
      logic [3:0] len;
      case (m)
         M_GET:    len = 4'd3;
         M_POST:   len = 4'd4;
         M_HEAD:   len = 4'd4;
         M_PUT:    len = 4'd3;
         M_DELETE: len = 4'd6;
         default:  len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] meth_char(logic [2:0] m, logic [3:0] pos);
      logic [47:0] name;
      logic [7:0]  ch;
      case (m)
         M_GET:    name = {"GET", 24'h0};
         M_POST:   name = {"POST", 16'h0};
         M_HEAD:   name = {"HEAD", 16'h0};
         M_PUT:    name = {"PUT", 24'h0};
         M_DELETE: name = "DELETE";
         default:  name = 48'h0;
      endcase
      case (pos)
         4'd0:    ch = name[47:40];
         4'd1:    ch = name[39:32];
         4'd2:    ch = name[31:24];
         4'd3:    ch = name[23:16];
         4'd4:    ch = name[15:8];
         4'd5:    ch = name[7:0];
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] ver_char(logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = VER_TEXT[55:48];
         4'd1:    ch = VER_TEXT[47:40];
         4'd2:    ch = VER_TEXT[39:32];
         4'd3:    ch = VER_TEXT[31:24];
         4'd4:    ch = VER_TEXT[23:16];
         4'd5:    ch = VER_TEXT[15:8];
         4'd6:    ch = VER_TEXT[7:0];
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [3:0] count_up(logic [3:0] cnt);
      return (cnt < COUNT_MAX) ? cnt + 4'd1 : cnt;
   endfunction

   // Applies one content byte to the parser state and gives the byte's role.
   function automatic content_type take_content(state_type s, logic [7:0] b);
      content_type r;
      r.st   = s;
      r.role = ROLE_DELIM;
      case (s.phase)
         PH_METHOD: begin
            if (b == CH_SPACE) begin
               for (int i = 0; i < NUM_METHODS; i++) begin
                  if (meth_len(3'(i)) != s.token_count) r.st.method_match[i] = 1'b0;
               end
               r.st.token_count = 4'd0;
               r.st.phase       = PH_PATH;
            end else begin
               for (int i = 0; i < NUM_METHODS; i++) begin
                  if (s.token_count >= meth_len(3'(i)) ||
                      meth_char(3'(i), s.token_count) != b) begin
                     r.st.method_match[i] = 1'b0;
                  end
               end
               r.st.token_count = count_up(s.token_count);
               r.role           = ROLE_METHOD;
            end
         end
         PH_PATH: begin
            if (b == CH_SPACE) begin
               r.st.phase       = PH_VERSION;
               r.st.token_count = 4'd0;
               r.st.version_ok  = 1'b1;
            end else begin
               if (b == CH_QUEST) r.st.path_in_query = 1'b1;
               r.role = r.st.path_in_query ? ROLE_QUERY : ROLE_PATH;
            end
         end
         PH_VERSION: begin
            if (s.token_count < VER_PREFIX) begin
               if (ver_char(s.token_count) != b) r.st.version_ok = 1'b0;
            end else if (s.token_count == VER_PREFIX) begin
               if (b == CH_ZERO) r.st.minor_digit = 1'b0;
               else if (b == CH_ONE) r.st.minor_digit = 1'b1;
               else r.st.version_ok = 1'b0;
            end else begin
               r.st.version_ok = 1'b0;
            end
            r.st.token_count = count_up(s.token_count);
            r.role           = ROLE_VERSION;
         end
         PH_HNAME: begin
            if (b == CH_COLON) r.st.phase = PH_HVALUE;
            else r.role = ROLE_HNAME;
         end
         PH_HVALUE: r.role = ROLE_HVALUE;
         default:   r.role = ROLE_DELIM;
      endcase
      return r;
   endfunction

   // Closes the current line at CR LF and reports what the line was.
   function automatic line_type end_line(state_type s);
      line_type r;
      r.st          = s;
      r.event_res   = EV_ERROR;
      r.method_code = M_GET;
      r.http_minor  = 1'b0;
      case (s.phase)
         PH_VERSION: begin
            if (s.version_ok && s.token_count == VER_LEN && s.method_match != 5'd0) begin
               r.event_res = EV_REQ_OK;
               for (int i = NUM_METHODS - 1; i >= 0; i--) begin
                  if (s.method_match[i]) r.method_code = 3'(i);
               end
               r.http_minor = s.minor_digit;
               r.st.phase   = PH_HNAME;
            end else begin
               r.st.phase = PH_ERROR;
            end
         end
         PH_HNAME: begin
            r.event_res = EV_COMPLETE;
            r.st.phase  = PH_DONE;
         end
         PH_HVALUE: begin
            r.event_res = EV_HDR_DONE;
            r.st.phase  = PH_HNAME;
         end
         default: r.st.phase = PH_ERROR;
      endcase
      return r;
   endfunction

endpackage

// ----- design/hrp_parse.sv -----
// Parser state register and the per-byte classification logic.
// Depends on hrp_pkg for the state type and the step functions.
module hrp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 new_request,
   output hrp_pkg::result_type  result
);
   import hrp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_type   cur;
      state_type   mid;
      content_type c_cr;
      content_type c_byte;
      line_type    line;

      cur  = new_request ? RESET_STATE : state_ff;
      mid  = cur;
      c_cr   = take_content(cur, CH_CR);
      c_byte = take_content(cur, data_byte);
      line   = end_line(cur);

      state_in           = cur;
      result.role        = ROLE_DELIM;
      result.out_byte    = data_byte;
      result.event_res   = EV_NONE;
      result.method_code = M_GET;
      result.http_minor  = 1'b0;

      if (cur.phase == PH_DONE || cur.phase == PH_ERROR) begin
         state_in.cr_pending = 1'b0;
      end else if (cur.cr_pending && data_byte == CH_LF) begin
         state_in            = line.st;
         state_in.cr_pending = 1'b0;
         result.event_res    = line.event_res;
         result.method_code  = line.method_code;
         result.http_minor   = line.http_minor;
      end else begin
         // A held CR that is not followed by LF is content of the current token.
         if (cur.cr_pending) mid = c_cr.st;
         mid.cr_pending = 1'b0;
         c_byte = take_content(mid, data_byte);
         if (data_byte == CH_CR) begin
            state_in            = mid;
            state_in.cr_pending = 1'b1;
         end else begin
            state_in    = c_byte.st;
            result.role = c_byte.role;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RESET_STATE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/hrp_out_stage.sv -----
// Result register between the parser and the result channel.
// Depends on hrp_pkg for the result type.
module hrp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  hrp_pkg::result_type  load_data,
   output logic                 can_load,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hrp_pkg::result_type  out_data
);
   import hrp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/http_request_head_parser.sv -----
// Top level of the HTTP request head byte tagger.
// Depends on hrp_pkg, hrp_parse and hrp_out_stage.
//
// Each word on the req channel carries one byte of an HTTP request head, with
// req_tuser set on the first byte of a new request. Each accepted word gives
// exactly one word on the rsp channel: the byte, its role in rsp_tuser, and an
// event when a line closes at CR LF (request line ok with method and minor
// version, header line done, request complete, or a sticky error).
// A CR is tagged as a delimiter when it arrives and is folded into the
// current token if the next byte is not LF.
// An accepted word is registered and shown on rsp in the next cycle. Throughput
// is one word per cycle while rsp_tready is high, set by the single result register.
// When rsp_tready is low the result register holds its word and req_tready
// drops; a new word is taken in the same cycle that the held word leaves.
// Reset clears the result register and returns the parser to the method
// token of a request line; no word is shown until one is accepted.
module http_request_head_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] new_request
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] event_res,
                                    // [13:11] method_code, [14] http_minor, [15] zero
   output logic [2:0]  rsp_tuser    // [2:0] role
);
   import hrp_pkg::*;

   logic       accept;
   result_type parse_result;
   result_type rsp_result;

   assign accept = req_tvalid && req_tready;

   hrp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .new_request (req_tuser),
      .result      (parse_result)
   );

   hrp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (parse_result),
      .can_load  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {1'b0, rsp_result.http_minor, rsp_result.method_code,
                       rsp_result.event_res, rsp_result.out_byte};
   assign rsp_tuser = rsp_result.role;

`ifndef SYNTHESIS
   a_event_on_delim: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] != EV_NONE |-> rsp_tuser == ROLE_DELIM)
      else $error("event reported on a non-delimiter byte");

   a_method_only_with_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] != EV_REQ_OK |-> rsp_tdata[14:11] == 4'd0)
      else $error("method or version reported without request line event");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result register is stalled");
`endif

endmodule

// ----- tb/tb_http_request_head_parser.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for http_request_head_parser: byte-by-byte role and event checks.
// A built-in parser model predicts every rsp word; depends on hrp_pkg and the DUT only.
module tb_http_request_head_parser;
   import hrp_pkg::*;

   localparam int OPENING = 31;
   localparam int ITEMS = 450;
   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 60;

   localparam int RX_FREE = 0;
   localparam int RX_COIN = 1;
   localparam int RX_SLOW = 2;
   localparam int RX_TOGGLE = 3;

   typedef struct packed {
      logic [2:0] role;
      logic [7:0] data;
      logic [2:0] ev;
      logic [2:0] meth;
      logic       minor;
   } tag_word_type;

   typedef struct packed {
      logic [7:0]   data;
      logic         fresh;
      logic         given;
      tag_word_type want;
   } feed_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   string method_text [5] = '{"GET", "POST", "HEAD", "PUT", "DELETE"};
   string ver_head = "HTTP/1.";

   // The opening rows walk one full request, a lone CR, a bare LF, and a sticky error.
   feed_word_type opening_rows [OPENING] = '{
      '{"G", 1'b1, 1'b1, '{ROLE_METHOD, "G", EV_NONE, M_GET, 1'b0}},
      '{"E", 1'b0, 1'b0, '0}, '{"T", 1'b0, 1'b0, '0}, '{" ", 1'b0, 1'b0, '0},
      '{"/", 1'b0, 1'b0, '0}, '{"?", 1'b0, 1'b0, '0}, '{" ", 1'b0, 1'b0, '0},
      '{"H", 1'b0, 1'b0, '0}, '{"T", 1'b0, 1'b0, '0}, '{"T", 1'b0, 1'b0, '0},
      '{"P", 1'b0, 1'b0, '0}, '{"/", 1'b0, 1'b0, '0}, '{"1", 1'b0, 1'b0, '0},
      '{".", 1'b0, 1'b0, '0}, '{"1", 1'b0, 1'b0, '0},
      '{CH_CR, 1'b0, 1'b1, '{ROLE_DELIM, CH_CR, EV_NONE, M_GET, 1'b0}},
      '{CH_LF, 1'b0, 1'b1, '{ROLE_DELIM, CH_LF, EV_REQ_OK, M_GET, 1'b1}},
      '{"H", 1'b0, 1'b0, '0}, '{":", 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{ROLE_HVALUE, 8'hFF, EV_NONE, M_GET, 1'b0}},
      '{CH_CR, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{CH_LF, 1'b0, 1'b0, '0},
      '{CH_CR, 1'b0, 1'b0, '0}, '{CH_LF, 1'b0, 1'b0, '0}, '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b0, 1'b1, '{ROLE_DELIM, CH_LF, EV_COMPLETE, M_GET, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, '{ROLE_METHOD, 8'hFF, EV_NONE, M_GET, 1'b0}},
      '{CH_CR, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b0, 1'b1, '{ROLE_DELIM, CH_LF, EV_ERROR, M_GET, 1'b0}},
      '{"A", 1'b0, 1'b1, '{ROLE_DELIM, "A", EV_NONE, M_GET, 1'b0}}
   };

   feed_word_type feed [$];
   feed_word_type offered [$];
   tag_word_type  pending_tags [$];
   int         errors = 0;
   int         junk_count = 0;
   int         cycles = 0;
   bit         fresh_next = 1'b0;
   bit         hold_req = 1'b0;

   logic [2:0] ph;
   logic [3:0] tok_len;
   logic [4:0] meth_ok;
   logic       ver_good;
   logic       minor_bit;
   logic       cr_held;
   logic       in_query;

   http_request_head_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void restart_parse();
      ph = PH_METHOD;
      tok_len = 4'd0;
      meth_ok = 5'h1F;
      ver_good = 1'b1;
      minor_bit = 1'b0;
      cr_held = 1'b0;
      in_query = 1'b0;
   endfunction

   // Feeds one content byte to the current token and returns its role.
   function automatic logic [2:0] tag_content(logic [7:0] b);
      logic [2:0] role;
      role = ROLE_DELIM;
      case (ph)
         PH_METHOD: begin
            if (b == CH_SPACE) begin
               for (int m = 0; m < 5; m++)
                  if (method_text[m].len() != tok_len) meth_ok[m] = 1'b0;
               tok_len = 4'd0;
               ph = PH_PATH;
            end else begin
               for (int m = 0; m < 5; m++)
                  if (tok_len >= method_text[m].len() || method_text[m][tok_len] != b)
                     meth_ok[m] = 1'b0;
               if (tok_len < COUNT_MAX) tok_len = tok_len + 4'd1;
               role = ROLE_METHOD;
            end
         end
         PH_PATH: begin
            if (b == CH_SPACE) begin
               ph = PH_VERSION;
               tok_len = 4'd0;
               ver_good = 1'b1;
            end else begin
               if (b == CH_QUEST) in_query = 1'b1;
               role = in_query ? ROLE_QUERY : ROLE_PATH;
            end
         end
         PH_VERSION: begin
            if (tok_len < ver_head.len()) begin
               if (ver_head[tok_len] != b) ver_good = 1'b0;
            end else if (tok_len == ver_head.len()) begin
               if (b == CH_ZERO) minor_bit = 1'b0;
               else if (b == CH_ONE) minor_bit = 1'b1;
               else ver_good = 1'b0;
            end else begin
               ver_good = 1'b0;
            end
            if (tok_len < COUNT_MAX) tok_len = tok_len + 4'd1;
            role = ROLE_VERSION;
         end
         PH_HNAME: begin
            if (b == CH_COLON) ph = PH_HVALUE;
            else role = ROLE_HNAME;
         end
         PH_HVALUE: role = ROLE_HVALUE;
         default: role = ROLE_DELIM;
      endcase
      return role;
   endfunction

   function automatic tag_word_type predict_tag(logic [7:0] b, logic fresh);
      tag_word_type r;
      if (fresh) restart_parse();
      r = '{ROLE_DELIM, b, EV_NONE, M_GET, 1'b0};
      if (ph == PH_DONE || ph == PH_ERROR) begin
         cr_held = 1'b0;
         return r;
      end
      if (cr_held) begin
         cr_held = 1'b0;
         if (b == CH_LF) begin
            case (ph)
               PH_VERSION: begin
                  if (ver_good && tok_len == 4'd8 && meth_ok != 5'd0) begin
                     r.ev = EV_REQ_OK;
                     for (int m = 4; m >= 0; m--)
                        if (meth_ok[m]) r.meth = 3'(m);
                     r.minor = minor_bit;
                     ph = PH_HNAME;
                  end else begin
                     r.ev = EV_ERROR;
                     ph = PH_ERROR;
                  end
               end
               PH_HNAME: begin
                  r.ev = EV_COMPLETE;
                  ph = PH_DONE;
               end
               PH_HVALUE: begin
                  r.ev = EV_HDR_DONE;
                  ph = PH_HNAME;
               end
               default: begin
                  r.ev = EV_ERROR;
                  ph = PH_ERROR;
               end
            endcase
            return r;
         end
         void'(tag_content(CH_CR));
      end
      if (b == CH_CR) begin
         cr_held = 1'b1;
         return r;
      end
      r.role = tag_content(b);
      return r;
   endfunction

   function automatic logic [7:0] token_char();
      logic [7:0] c;
      if ($urandom_range(0, 7) == 0) begin
         c = 8'($urandom_range(128, 255));
      end else begin
         do c = 8'($urandom_range(33, 126)); while (c == CH_COLON);
      end
      return c;
   endfunction

   task automatic add_byte(logic [7:0] b);
      feed.push_back('{b, fresh_next, 1'b0, '0});
      fresh_next = 1'b0;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_line_end();
      if ($urandom_range(0, 9) == 0) add_byte(CH_CR);
      add_byte(CH_CR);
      add_byte(CH_LF);
   endtask

   // Appends one request head, mostly well formed, sometimes broken or pure noise.
   task automatic add_request();
      int pick;
      int n;
      logic [7:0] c;
      string verb;
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
         n = $urandom_range(3, 12);
         repeat (n) begin
            fresh_next = 1'($urandom_range(0, 1));
            add_byte(8'($urandom_range(0, 255)));
         end
         return;
      end
      fresh_next = 1'b1;
      verb = method_text[$urandom_range(0, 4)];
      case (pick == 1 ? $urandom_range(1, 3) : 0)
         0: add_text(verb);
         1: repeat ($urandom_range(1, 17)) add_byte(token_char());
         2: add_text(verb.substr(0, verb.len() - 2));
         default: begin
            add_text(verb);
            add_byte(token_char());
         end
      endcase
      add_byte(CH_SPACE);
      if ($urandom_range(0, 3) != 0) add_byte("/");
      n = $urandom_range(0, 6);
      repeat (n) add_byte(($urandom_range(0, 4) == 0) ? CH_QUEST : token_char());
      if (pick == 2) begin
         add_line_end();
         return;
      end
      add_byte(CH_SPACE);
      if (pick == 3) begin
         case ($urandom_range(0, 3))
            0: begin
               add_text(ver_head);
               add_byte(token_char());
            end
            1: begin
               add_text("HTTP/1.1");
               repeat ($urandom_range(1, 10)) add_byte(token_char());
            end
            2: add_text("HTTP/1");
            default: add_text("HTTQ/1.0");
         endcase
      end else begin
         add_text(ver_head);
         add_byte($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
      end
      add_line_end();
      if (pick == 4) return;
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(1, 6)) add_byte(token_char());
         add_byte(CH_COLON);
         repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 11))
               0: begin
                  add_byte(CH_CR);
                  add_byte(token_char());
               end
               1: add_byte(CH_LF);
               default: begin
                  do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
                  add_byte(c);
               end
            endcase
         end
         add_line_end();
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 5)) add_byte(token_char());
      add_line_end();
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            add_byte(8'($urandom_range(0, 255)));
            junk_count++;
         end
      end
   endtask

   task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         errors++;
      end
   endtask

   initial begin : sender
      int gap;
      int burst_left;
      int half;
      feed_word_type w;
      restart_parse();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_rows[i]) feed.push_back(opening_rows[i]);
      while (feed.size() - OPENING - junk_count < ITEMS) add_request();
      half = OPENING + (feed.size() - OPENING) / 2;
      burst_left = 0;
      for (int i = 0; i < feed.size(); i++) begin
         if (i == OPENING || i == half) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_tags.size() != 0) @(posedge clock);
            if (i == OPENING) hold_req = 1'b1;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         w = feed[i];
         offered.push_back(w);
         req_tvalid <= 1'b1;
         req_tdata <= w.data;
         req_tuser <= w.fresh;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (errors == 0) $display("tb_http_request_head_parser: clean");
      else $display("tb_http_request_head_parser: errors");
      $finish;
   end

   initial begin : receiver
      int mode;
      int run;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(RX_FREE, RX_TOGGLE);
         run = $urandom_range(8, 40);
         repeat (run) begin
            case (mode)
               RX_FREE: rsp_tready <= 1'b1;
               RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
               RX_SLOW: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : monitor
      feed_word_type note;
      tag_word_type guess;
      tag_word_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            note = offered.pop_front();
            guess = predict_tag(req_tdata, req_tuser);
            pending_tags.push_back(note.given ? note.want : guess);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_tags.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0h/%0h",
                        $time, rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               want = pending_tags.pop_front();
               check_field("role", 8'(want.role), 8'(rsp_tuser));
               check_field("out_byte", want.data, rsp_tdata[7:0]);
               check_field("event_res", 8'(want.ev), 8'(rsp_tdata[10:8]));
               check_field("method_code", 8'(want.meth), 8'(rsp_tdata[13:11]));
               check_field("http_minor", 8'(want.minor), 8'(rsp_tdata[14]));
               check_field("pad bit", 8'h00, 8'(rsp_tdata[15]));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_http_request_head_parser: errors");
         $finish;
      end
   end

endmodule

// ----- http_request_head_parser.f -----
design/hrp_pkg.sv
design/hrp_parse.sv
design/hrp_out_stage.sv
design/http_request_head_parser.sv
tb/tb_http_request_head_parser.sv
